// ----- rtl/pldz_pkg.sv -----
// Shared constants, types and config register codes for the delta/zigzag codec.
`timescale 1ns / 1ps
package pldz_pkg;

  localparam int LANES       = 64;
  localparam int LANE_AW     = $clog2(LANES);
  localparam int LANE_W      = 6;
  localparam int VALUE_W     = 64;
  localparam int VBITS_W     = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = VBITS_W;
  localparam int QDEPTH      = 2;
  localparam int QAW         = $clog2(QDEPTH);

  localparam logic [VBITS_W-1:0] VBITS_RESET = VBITS_W'(16);
  localparam logic [VBITS_W-1:0] VBITS_MAX   = VBITS_W'(VALUE_W);

  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_BITS = CFG_IDX_W'(1);

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_t;

  // Classified item handed from front to back.
  typedef struct packed {
    dir_t               dir;
    logic [LANE_W-1:0]  lane;
    logic               start;
    logic               err;      // decode code wider than the value width
    logic [VALUE_W-1:0] mask;     // low value_bits ones
    logic [VALUE_W-1:0] topbit;   // one-hot sign bit position
    logic [VALUE_W-1:0] operand;  // masked raw (encode) or un-zigzagged delta (decode)
  } op_t;

endpackage

// ----- rtl/pldz_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pldz_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/pldz_front.sv -----
// Front end: classifies an incoming sample against the current configuration.
`timescale 1ns / 1ps
module pldz_front import pldz_pkg::*; (
  input  logic [VALUE_W-1:0] sample_value,
  input  logic [LANE_W-1:0]  lane,
  input  logic               start_record,
  input  dir_t               direction,
  input  logic [VBITS_W-1:0] value_bits,
  output op_t                op
);

  logic [VBITS_W-1:0] eff_w;
  logic [VALUE_W-1:0] mask;
  logic [VALUE_W-1:0] unzig;

  always_comb begin
    if (value_bits == '0) begin
      eff_w = VBITS_W'(1);
    end else if (value_bits > VBITS_MAX) begin
      eff_w = VBITS_MAX;
    end else begin
      eff_w = value_bits;
    end
  end

  assign mask  = (eff_w == VBITS_MAX) ? '1 : ~({VALUE_W{1'b1}} << eff_w[LANE_W-1:0]);
  assign unzig = ((sample_value >> 1) ^ {VALUE_W{sample_value[0]}}) & mask;

  always_comb begin
    op.dir    = direction;
    op.lane   = lane;
    op.start  = start_record;
    op.mask   = mask;
    op.topbit = mask ^ (mask >> 1);
    op.err    = (direction == DIR_DECODE) && ((sample_value & ~mask) != '0);
    op.operand = (direction == DIR_DECODE) ? unzig : (sample_value & mask);
  end

endmodule

// ----- rtl/pldz_fifo.sv -----
// Short queue of classified items between the front and back ends.
`timescale 1ns / 1ps
module pldz_fifo import pldz_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_data,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output op_t  head
);

  op_t              mem_r [QDEPTH];
  logic [QAW-1:0]   wptr_r, wptr_nxt;
  logic [QAW-1:0]   rptr_r, rptr_nxt;
  logic [QAW:0]     count_r, count_nxt;

  assign full      = (count_r == (QAW+1)'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = push ? wptr_r + QAW'(1) : wptr_r;
    rptr_nxt  = pop ? rptr_r + QAW'(1) : rptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (QAW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/pldz_back.sv -----
// Back end: lane history lookup, delta/zigzag arithmetic, history update, output register.
`timescale 1ns / 1ps
module pldz_back import pldz_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  op_t                q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [VALUE_W-1:0] out_result_value,
  output logic               out_range_error
);

  op_t                 b1_r;
  logic                b1_valid_r;
  logic [LANES-1:0]    lane_valid_r, lane_valid_nxt;
  logic [LANE_AW-1:0]  fwd_lane_r;
  logic [VALUE_W-1:0]  fwd_data_r;
  logic                out_valid_r;
  logic [VALUE_W-1:0]  out_value_r;
  logic                out_err_r;

  logic [VALUE_W-1:0]  rdata;
  logic [VALUE_W-1:0]  hist;
  logic [VALUE_W-1:0]  prev;
  logic [VALUE_W-1:0]  delta;
  logic [VALUE_W-1:0]  fill;
  logic [VALUE_W-1:0]  ext;
  logic [VALUE_W-1:0]  result;
  logic [VALUE_W-1:0]  hist_wdata;
  logic                range_err;
  logic                hist_we;
  logic                fire;
  logic [LANE_AW-1:0]  b1_idx;

  assign b1_idx = b1_r.lane[LANE_AW-1:0];
  assign fire   = b1_valid_r && (!out_valid_r || out_ready);
  assign q_pop  = q_not_empty && (!b1_valid_r || fire);

  pldz_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (LANES)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (b1_idx),
    .wdata (hist_wdata),
    .re    (q_pop),
    .raddr (q_head.lane[LANE_AW-1:0]),
    .rdata (rdata)
  );

  // RAM read is read-first; the write retiring on the same edge as a pop is forwarded.
  always_comb begin
    hist  = (fwd_lane_r == b1_idx) ? fwd_data_r : rdata;
    prev  = (!b1_r.start && lane_valid_r[b1_idx]) ? hist : '0;
    range_err = b1_r.err;
    delta = '0;
    fill  = '0;
    ext   = '0;
    if (b1_r.dir == DIR_ENCODE) begin
      delta  = (b1_r.operand - prev) & b1_r.mask;
      fill   = {VALUE_W{(delta & b1_r.topbit) != '0}};
      ext    = delta | (fill & ~b1_r.mask);
      result = ((ext << 1) ^ fill) & b1_r.mask;
    end else if (range_err) begin
      result = '0;
    end else begin
      result = (prev + b1_r.operand) & b1_r.mask;
    end
    // encode keeps the masked raw value as history, decode keeps the rebuilt value
    hist_wdata = (b1_r.dir == DIR_ENCODE) ? b1_r.operand : result;
    hist_we = fire && !range_err;
  end

  always_comb begin
    lane_valid_nxt = lane_valid_r;
    if (fire) begin
      if (b1_r.start) begin
        lane_valid_nxt = '0;
      end
      if (!range_err) begin
        lane_valid_nxt[b1_idx] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      lane_valid_r <= '0;
    end else begin
      lane_valid_r <= lane_valid_nxt;
      if (q_pop) begin
        b1_valid_r <= 1'b1;
      end else if (fire) begin
        b1_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1_r <= q_head;
    end
    if (hist_we) begin
      fwd_lane_r <= b1_idx;
      fwd_data_r <= hist_wdata;
    end
    if (fire) begin
      out_value_r <= result;
      out_err_r   <= range_err;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_range_error  = out_err_r;

endmodule

// ----- rtl/per_lane_delta_zigzag_codec_core.sv -----
// Path from input acceptance: queue, history read, output register, then out_valid.
// With out_ready high: one transaction and one history RAM read and write per cycle.
// A two-entry queue decouples input acceptance from the history pipeline and output stalls.
// Reset (synchronous, rst_n low): direction = encode, value_bits = 16, all lanes read as zero.
// Lane history RAM is not swept; per-lane valid flops cleared by reset mask stale entries.
`timescale 1ns / 1ps
module per_lane_delta_zigzag_codec_core import pldz_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_W-1:0]    in_sample_value,
  input  logic [LANE_W-1:0]     in_lane,
  input  logic                  in_start_record,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VALUE_W-1:0]    out_result_value,
  output logic                  out_range_error
);

  dir_t               direction_r;
  logic [VBITS_W-1:0] value_bits_r;
  op_t                front_op;
  op_t                q_head;
  logic               q_full;
  logic               q_not_empty;
  logic               q_pop;
  logic               push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r  <= DIR_ENCODE;
      value_bits_r <= VBITS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIRECTION:  direction_r  <= dir_t'(cfg_wdata[0]);
        REG_VALUE_BITS: value_bits_r <= cfg_wdata[VBITS_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  pldz_front u_front (
    .sample_value (in_sample_value),
    .lane         (in_lane),
    .start_record (in_start_record),
    .direction    (direction_r),
    .value_bits   (value_bits_r),
    .op           (front_op)
  );

  pldz_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_op),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  pldz_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_range_error  (out_range_error)
  );

endmodule
